// ----- src/lprl_pkg.sv -----
package lprl_pkg;

    localparam int ADDR_W  = 32;
    localparam int IFACE_W = 4;
    localparam int LEN_W   = 6;

    typedef enum logic
    {
        ACT_ADD    = 1'b0,
        ACT_LOOKUP = 1'b1
    } lprl_action_t;

    typedef enum logic [1:0]
    {
        ST_ADDED    = 2'd0,
        ST_FULL     = 2'd1,
        ST_MATCH    = 2'd2,
        ST_NO_MATCH = 2'd3
    } lprl_status_t;

    typedef struct packed
    {
        lprl_action_t        action;
        logic [ADDR_W-1:0]   address;
        logic [ADDR_W-1:0]   new_gateway;
        logic [ADDR_W-1:0]   new_mask;
        logic [IFACE_W-1:0]  new_iface;
    } lprl_req_t;

    typedef struct packed
    {
        lprl_status_t        status;
        logic [ADDR_W-1:0]   hit_destination;
        logic [ADDR_W-1:0]   hit_gateway;
        logic [ADDR_W-1:0]   hit_mask;
        logic [IFACE_W-1:0]  hit_iface;
        logic [LEN_W-1:0]    hit_length;
    } lprl_rsp_t;

    typedef struct packed
    {
        logic [ADDR_W-1:0]   destination;
        logic [ADDR_W-1:0]   gateway;
        logic [ADDR_W-1:0]   mask;
        logic [IFACE_W-1:0]  iface;
        logic [LEN_W-1:0]    length;
    } lprl_entry_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_WAIT,
        S_DONE
    } lprl_state_t;

    typedef struct packed
    {
        logic load_req;
        logic do_add;
        logic scan_clear;
        logic rd_en;
        logic load_out;
    } lprl_cmd_t;

    typedef struct packed
    {
        logic is_lookup;
        logic empty;
        logic last_rd;
        logic out_busy;
    } lprl_stat_t;

endpackage

// ----- src/lprl_stream_if.sv -----
interface lprl_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source
    (
        output valid,
        output payload,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// ----- src/lprl_ram.sv -----
module lprl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/lprl_datapath.sv -----
module lprl_datapath
    import lprl_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  lprl_cmd_t  cmd,
    output lprl_stat_t stat,
    input  lprl_req_t  req_payload,
    output logic       rsp_valid,
    output lprl_rsp_t  rsp_payload,
    input  logic       rsp_ready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    function automatic logic [LEN_W-1:0] prefix_len(input logic [ADDR_W-1:0] m);
        logic [ADDR_W-1:0] low;
        logic [4:0]        tz;
        low = m & (~m + ADDR_W'(1));
        tz  = '0;
        for (int i = 0; i < ADDR_W; i++)
        begin
            if (low[i])
            begin
                tz = tz | 5'(i);
            end
        end
        return (m == '0) ? '0 : (LEN_W'(ADDR_W) - {1'b0, tz});
    endfunction

    lprl_req_t    req_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic          found_reg, found_next;
    lprl_entry_t   best_reg, best_next;
    lprl_status_t  status_reg, status_next;
    logic          rsp_valid_reg, rsp_valid_next;
    lprl_rsp_t     rsp_reg, rsp_next;

    lprl_entry_t   new_entry;
    lprl_entry_t   rd_entry;
    logic          full;
    logic          wr_en;
    logic          hit;
    logic          take;

    assign full  = (cnt_reg == CW'(TABLE_DEPTH));
    assign wr_en = cmd.do_add && !full;

    always_comb
    begin
        new_entry.destination = req_reg.address;
        new_entry.gateway     = req_reg.new_gateway;
        new_entry.mask        = req_reg.new_mask;
        new_entry.iface       = req_reg.new_iface;
        new_entry.length      = prefix_len(req_reg.new_mask);
    end

    lprl_ram #(
        .WIDTH ($bits(lprl_entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (new_entry),
        .re    (cmd.rd_en),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (rd_entry)
    );

    assign hit  = ((req_reg.address & rd_entry.mask) == (rd_entry.destination & rd_entry.mask));
    assign take = cmp_vld_reg && hit && (!found_reg || (rd_entry.length > best_reg.length));

    always_comb
    begin
        cnt_next       = wr_en ? (cnt_reg + CW'(1)) : cnt_reg;
        rd_idx_next    = rd_idx_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        status_next    = status_reg;
        cmp_vld_next   = cmd.rd_en;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (cmd.do_add)
        begin
            status_next = full ? ST_FULL : ST_ADDED;
        end

        if (cmd.scan_clear)
        begin
            rd_idx_next = '0;
            found_next  = 1'b0;
        end
        else if (cmd.rd_en)
        begin
            rd_idx_next = rd_idx_reg + CW'(1);
        end

        if (take)
        begin
            found_next = 1'b1;
            best_next  = rd_entry;
        end

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cmd.load_out)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '0;
            if (req_reg.action == ACT_LOOKUP)
            begin
                if (found_reg)
                begin
                    rsp_next.status          = ST_MATCH;
                    rsp_next.hit_destination = best_reg.destination;
                    rsp_next.hit_gateway     = best_reg.gateway;
                    rsp_next.hit_mask        = best_reg.mask;
                    rsp_next.hit_iface       = best_reg.iface;
                    rsp_next.hit_length      = best_reg.length;
                end
                else
                begin
                    rsp_next.status = ST_NO_MATCH;
                end
            end
            else
            begin
                rsp_next.status = status_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_payload;
        end
        best_reg   <= best_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    assign stat.is_lookup = (req_reg.action == ACT_LOOKUP);
    assign stat.empty     = (cnt_reg == '0);
    assign stat.last_rd   = ((rd_idx_reg + CW'(1)) == cnt_reg);
    assign stat.out_busy  = rsp_valid_reg && !rsp_ready;

    assign rsp_valid   = rsp_valid_reg;
    assign rsp_payload = rsp_reg;

endmodule

// ----- src/lprl_ctrl.sv -----
module lprl_ctrl
    import lprl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  lprl_stat_t stat,
    output lprl_cmd_t  cmd
);

    lprl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!stat.is_lookup)
                begin
                    cmd.do_add = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = stat.empty ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (stat.last_rd)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/longest_prefix_route_lookup_top.sv -----
// channel  dir  payload      transfer
// req      in   lprl_req_t   valid & ready
// rsp      out  lprl_rsp_t   valid & ready
//
// add: one table write in DECODE, result loaded in DONE
// lookup: SCAN reads one entry per cycle, then WAIT; an empty table skips both
// reset clears the entry count and scan/output state, route memory is not swept
// a finished result waits in the output register while rsp stalls, the next
// request is taken meanwhile and its result waits until that register frees
module longest_prefix_route_lookup_top
    import lprl_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input logic           clk,
    input logic           rst_n,
    lprl_stream_if.sink   req,
    lprl_stream_if.source rsp
);

    lprl_cmd_t  cmd;
    lprl_stat_t stat;
    lprl_req_t  req_payload;
    lprl_rsp_t  rsp_payload;
    logic       req_ready;
    logic       rsp_valid;

    assign req_payload = req.payload;

    lprl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lprl_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_payload (req_payload),
        .rsp_valid   (rsp_valid),
        .rsp_payload (rsp_payload),
        .rsp_ready   (rsp.ready)
    );

    assign req.ready   = req_ready;
    assign rsp.valid   = rsp_valid;
    assign rsp.payload = rsp_payload;

endmodule
